// File: rtl/bsst_pkg.sv
// shared types and constants for the sorted table search block
package bsst_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 10;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/bsst_if.sv
// valid/ready channel interfaces for the input and result words
interface bsst_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    cmd;
  logic signed [bsst_pkg::WordW-1:0]       data_word;

  modport source (output valid, cmd, data_word, input ready);
  modport sink   (input valid, cmd, data_word, output ready);
endinterface

interface bsst_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [bsst_pkg::PosW-1:0]     position;
  logic                          overflowed;

  modport source (output valid, found, position, overflowed, input ready);
  modport sink   (input valid, found, position, overflowed, output ready);
endinterface

// File: rtl/bsst_mem.sv
// table memory, one write port and one registered read port
module bsst_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [bsst_pkg::WordW-1:0]    wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [bsst_pkg::WordW-1:0]    rdata
);

  logic [bsst_pkg::WordW-1:0] mem [DEPTH];
  logic [bsst_pkg::WordW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/binary_search_sorted_table_top.sv
// top level of the sorted table search block
// Append words load the table from index 0 in arrival order, back to back; the user
// must append them in ascending order, which the block itself does not enforce. The
// first append after a search starts a new table, and appends past DEPTH are dropped
// and flagged in the next result. A search bisects the loaded entries with one table
// memory read per probe: the search word is accepted in the idle state, each probe
// passes through a read state and a compare state, and a miss ends with a final
// bounds check in the read state before the emit state writes the result. One word is
// worked on at a time; the next input word is taken while a result still waits in the output register.
module binary_search_sorted_table_top #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  bsst_in_if.sink         in_if,
  bsst_out_if.source      out_if
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bsst_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic          fresh_r, fresh_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] low_r, low_nxt;
  logic [CW-1:0] hi1_r, hi1_nxt;
  logic [AW-1:0] mid_r, mid_nxt;
  logic          hit_r, hit_nxt;
  logic signed [bsst_pkg::WordW-1:0] key_r, key_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      found_r, found_nxt;
  logic [bsst_pkg::PosW-1:0] position_r, position_nxt;
  logic                      overflowed_r, overflowed_nxt;

  logic                      in_take;
  logic                      is_search;
  logic [CW-1:0]             count_eff;
  logic [CW:0]               sum;
  logic [AW-1:0]             mid_calc;
  logic                      range_ok;
  logic                      slot_free;
  logic                      mem_we;
  logic                      mem_re;
  logic [bsst_pkg::WordW-1:0] rdata;

  bsst_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(count_eff)),
    .wdata (in_if.data_word),
    .re    (mem_re),
    .raddr (mid_calc),
    .rdata (rdata)
  );

  assign in_if.ready = rst_n && (state_r == bsst_pkg::ST_IDLE);
  assign in_take   = in_if.valid && in_if.ready;
  assign is_search = (in_if.cmd == bsst_pkg::CMD_SEARCH);
  assign count_eff = fresh_r ? '0 : count_r;
  assign sum       = {1'b0, low_r} + {1'b0, hi1_r} - (CW + 1)'(1);
  assign mid_calc  = AW'(sum[CW:1]);
  assign range_ok  = (low_r < hi1_r);
  assign slot_free = !out_valid_r || out_if.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsst_pkg::ST_IDLE: begin
        if (in_take && is_search) begin
          state_nxt = bsst_pkg::ST_READ;
        end
      end
      bsst_pkg::ST_READ: begin
        state_nxt = range_ok ? bsst_pkg::ST_CMP : bsst_pkg::ST_EMIT;
      end
      bsst_pkg::ST_CMP: begin
        state_nxt = ($signed(rdata) == key_r) ? bsst_pkg::ST_EMIT : bsst_pkg::ST_READ;
      end
      bsst_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_nxt = bsst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bsst_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    count_nxt      = count_r;
    fresh_nxt      = fresh_r;
    drop_nxt       = drop_r;
    low_nxt        = low_r;
    hi1_nxt        = hi1_r;
    mid_nxt        = mid_r;
    hit_nxt        = hit_r;
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    found_nxt      = found_r;
    position_nxt   = position_r;
    overflowed_nxt = overflowed_r;
    case (state_r)
      bsst_pkg::ST_IDLE: begin
        if (in_take) begin
          if (is_search) begin
            key_nxt = in_if.data_word;
            low_nxt = '0;
            hi1_nxt = count_r;
            hit_nxt = 1'b0;
          end else begin
            fresh_nxt = 1'b0;
            if (count_eff < CW'(DEPTH)) begin
              mem_we    = 1'b1;
              count_nxt = count_eff + CW'(1);
            end else begin
              drop_nxt  = 1'b1;
              count_nxt = count_eff;
            end
          end
        end
      end
      bsst_pkg::ST_READ: begin
        mem_re  = range_ok;
        mid_nxt = mid_calc;
      end
      bsst_pkg::ST_CMP: begin
        if ($signed(rdata) == key_r) begin
          hit_nxt = 1'b1;
        end else if ($signed(rdata) > key_r) begin
          hi1_nxt = CW'(mid_r);
        end else begin
          low_nxt = CW'(mid_r) + CW'(1);
        end
      end
      bsst_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          found_nxt      = hit_r;
          position_nxt   = hit_r ? bsst_pkg::PosW'(mid_r) : '0;
          overflowed_nxt = drop_r;
          drop_nxt       = 1'b0;
          fresh_nxt      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsst_pkg::ST_IDLE;
      count_r     <= '0;
      fresh_r     <= 1'b0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r        <= low_nxt;
    hi1_r        <= hi1_nxt;
    mid_r        <= mid_nxt;
    hit_r        <= hit_nxt;
    key_r        <= key_nxt;
    found_r      <= found_nxt;
    position_r   <= position_nxt;
    overflowed_r <= overflowed_nxt;
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.found      = found_r;
  assign out_if.position   = position_r;
  assign out_if.overflowed = overflowed_r;

endmodule
